// File: design/rbs_pkg.sv
// ---------------------------------------------------------------------------
// rbs_pkg
// Shared widths, constants and control/status types of the request block
// splitter.
// ---------------------------------------------------------------------------
package rbs_pkg;

   // field widths
   localparam int TAG_W    = 32;
   localparam int ADDR_W   = 48;
   localparam int LEN_W    = 13;
   localparam int BLKNUM_W = 41;
   localparam int BOFF_W   = 16;
   localparam int ROFF_W   = 12;
   localparam int BSIZE_W  = 17;

   // block size limits and reset value
   localparam logic [BSIZE_W-1:0] BLOCK_RESET = 17'd4096;
   localparam logic [BSIZE_W-1:0] BLOCK_MIN   = 17'd128;
   localparam logic [BSIZE_W-1:0] BLOCK_MAX   = 17'd65536;

   // longest request, longer ones are saturated
   localparam logic [LEN_W-1:0] MAX_REQUEST_BYTES = 13'd4096;

   // the smallest block is 2**7, so the top 7 quotient bits are always zero
   localparam int DIV_PRESET_W = ADDR_W - BLKNUM_W;
   localparam int DIV_STEPS    = BLKNUM_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load;      // take the request and seed the divider
      logic div_step;  // one restoring division step
      logic emit;      // write the next piece into the result register
   } cmd_type;

   typedef struct packed {
      logic zero_length;  // request on the input carries no bytes
      logic out_free;     // result register empty or being taken
      logic piece_last;   // the piece about to be emitted is the final one
   } status_type;

endpackage

// File: design/rbs_ctrl.sv
// ---------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: accepts a request, runs the divider, then walks the pieces.
// ---------------------------------------------------------------------------
module rbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rbs_pkg::status_type status,
   output rbs_pkg::cmd_type    cmd
);
   import rbs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.zero_length) begin
               cmd.load = 1'b1;
               cnt_in   = DIV_CNT_W'(DIV_STEPS - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.piece_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: design/rbs_datapath.sv
// ---------------------------------------------------------------------------
// rbs_datapath
// Block size register, bit-serial divider, piece walk and result register.
// ---------------------------------------------------------------------------
module rbs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rbs_pkg::BSIZE_W-1:0]   csr_wr_data,
   input  logic [rbs_pkg::TAG_W-1:0]     req_tag,
   input  logic [rbs_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [rbs_pkg::LEN_W-1:0]     req_byte_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rbs_pkg::TAG_W-1:0]     rsp_piece_tag,
   output logic [rbs_pkg::BLKNUM_W-1:0]  rsp_block_number,
   output logic [rbs_pkg::BOFF_W-1:0]    rsp_offset_in_block,
   output logic [rbs_pkg::ROFF_W-1:0]    rsp_offset_in_request,
   output logic [rbs_pkg::LEN_W-1:0]     rsp_piece_bytes,
   output logic                          rsp_last_piece,
   input  rbs_pkg::cmd_type              cmd,
   output rbs_pkg::status_type           status
);
   import rbs_pkg::*;

   logic [BSIZE_W-1:0]  block_ff;
   logic [BSIZE_W-1:0]  block_eff;

   // walk state
   logic [TAG_W-1:0]    tag_ff;
   logic [LEN_W-1:0]    length_ff;
   logic [LEN_W-1:0]    done_ff;
   logic                first_ff;
   logic [BOFF_W-1:0]   rem_ff;     // divider remainder, then first offset
   logic [BLKNUM_W-1:0] quo_ff;     // dividend bits out, quotient bits in

   // result register
   logic                out_valid_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   logic [BLKNUM_W-1:0] out_block_ff;
   logic [BOFF_W-1:0]   out_boff_ff;
   logic [ROFF_W-1:0]   out_roff_ff;
   logic [LEN_W-1:0]    out_bytes_ff;
   logic                out_last_ff;

   logic [BSIZE_W-1:0]  trial;
   logic                trial_ge;
   logic [LEN_W-1:0]    len_sat;
   logic [BOFF_W-1:0]   boff;
   logic [BSIZE_W-1:0]  room;       // bytes left in the current block
   logic [LEN_W-1:0]    remaining;
   logic                last;
   logic [LEN_W-1:0]    size;

   // out-of-range sizes clamp to the nearest legal one
   always_comb begin
      if (block_ff < BLOCK_MIN) begin
         block_eff = BLOCK_MIN;
      end else if (block_ff > BLOCK_MAX) begin
         block_eff = BLOCK_MAX;
      end else begin
         block_eff = block_ff;
      end
   end

   assign len_sat  = (req_byte_length > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES
                                                           : req_byte_length;
   assign trial    = {rem_ff, quo_ff[BLKNUM_W-1]};
   assign trial_ge = (trial >= block_eff);

   assign boff      = first_ff ? rem_ff : '0;
   assign room      = block_eff - {1'b0, boff};
   assign remaining = length_ff - done_ff;
   assign last      = ({{(BSIZE_W-LEN_W){1'b0}}, remaining} <= room);
   assign size      = last ? remaining : room[LEN_W-1:0];

   assign status.zero_length = (req_byte_length == '0);
   assign status.out_free    = !out_valid_ff || !rsp_stall;
   assign status.piece_last  = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff <= BLOCK_RESET;
      end else if (csr_wr_en) begin
         block_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff    <= req_tag;
         length_ff <= len_sat;
         done_ff   <= '0;
         first_ff  <= 1'b1;
         rem_ff    <= {{(BOFF_W-DIV_PRESET_W){1'b0}},
                       req_byte_address[ADDR_W-1 -: DIV_PRESET_W]};
         quo_ff    <= req_byte_address[BLKNUM_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? BOFF_W'(trial - block_eff) : trial[BOFF_W-1:0];
         quo_ff <= {quo_ff[BLKNUM_W-2:0], trial_ge};
      end else if (cmd.emit) begin
         done_ff  <= done_ff + size;
         first_ff <= 1'b0;
         quo_ff   <= quo_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_tag_ff   <= tag_ff;
         out_block_ff <= quo_ff;
         out_boff_ff  <= boff;
         out_roff_ff  <= done_ff[ROFF_W-1:0];
         out_bytes_ff <= size;
         out_last_ff  <= last;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_piece_tag         = out_tag_ff;
   assign rsp_block_number      = out_block_ff;
   assign rsp_offset_in_block   = out_boff_ff;
   assign rsp_offset_in_request = out_roff_ff;
   assign rsp_piece_bytes       = out_bytes_ff;
   assign rsp_last_piece        = out_last_ff;

endmodule

// File: design/request_block_splitter.sv
// ---------------------------------------------------------------------------
// request_block_splitter
// Cuts a memory request into one piece per block that it touches.
// ---------------------------------------------------------------------------
// Use:
//   Request beats (req_*) carry tag, byte address and byte length. Each beat
//   of non-zero length yields one result beat (rsp_*) per block touched, in
//   ascending block order, the final one marked by rsp_last_piece. A beat of
//   zero length is taken and yields nothing. Lengths above 4096 are cut to
//   4096.
//   csr_wr_en/csr_wr_data set the block size (any value, clamped to
//   128..65536); write it only while no request is in progress.
// Timing:
//   A bit-serial restoring divider finds block number and offset, one
//   quotient bit a cycle. The first piece is registered when the division
//   ends, then one piece a cycle while the result side takes them. A new
//   request is not taken until the final piece of the current one is
//   registered, but it is taken while that final piece still waits in the
//   result register.
// Reset:
//   Synchronous: the sequencer returns to idle, the result register empties
//   and the block size returns to 4096.
// Stall:
//   rsp_stall holds the current piece in the result register and pauses the
//   walk; the input stays stalled until the final piece is registered.
// ---------------------------------------------------------------------------
module request_block_splitter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rbs_pkg::BSIZE_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rbs_pkg::TAG_W-1:0]     req_tag,
   input  logic [rbs_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [rbs_pkg::LEN_W-1:0]     req_byte_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rbs_pkg::TAG_W-1:0]     rsp_piece_tag,
   output logic [rbs_pkg::BLKNUM_W-1:0]  rsp_block_number,
   output logic [rbs_pkg::BOFF_W-1:0]    rsp_offset_in_block,
   output logic [rbs_pkg::ROFF_W-1:0]    rsp_offset_in_request,
   output logic [rbs_pkg::LEN_W-1:0]     rsp_piece_bytes,
   output logic                          rsp_last_piece
);
   import rbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: idle, divide, emit
   rbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // divider, piece arithmetic and result register
   rbs_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_tag               (req_tag),
      .req_byte_address      (req_byte_address),
      .req_byte_length       (req_byte_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_piece_tag         (rsp_piece_tag),
      .rsp_block_number      (rsp_block_number),
      .rsp_offset_in_block   (rsp_offset_in_block),
      .rsp_offset_in_request (rsp_offset_in_request),
      .rsp_piece_bytes       (rsp_piece_bytes),
      .rsp_last_piece        (rsp_last_piece),
      .cmd                   (cmd),
      .status                (status)
   );

endmodule

// File: design/rbs_checker.sv
// ---------------------------------------------------------------------------
// rbs_checker
// Port-level checks on the request block splitter.
// ---------------------------------------------------------------------------
module rbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [rbs_pkg::LEN_W-1:0]     req_byte_length,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rbs_pkg::BLKNUM_W-1:0]  rsp_block_number,
   input logic [rbs_pkg::LEN_W-1:0]     rsp_piece_bytes,
   input logic                          rsp_last_piece
);

   // a stalled piece stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_number)
                                && $stable(rsp_piece_bytes))
      else $error("stalled result beat changed");

   // a request with bytes occupies the block
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_byte_length != '0) |=> req_stall)
      else $error("input not stalled after a non-empty request");

   // once idle, only the final piece of a request may still be pending
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall && rsp_valid |-> rsp_last_piece)
      else $error("idle with a non-final piece pending");

   // no empty pieces
   a_nonzero_piece: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_piece_bytes != '0))
      else $error("piece of zero bytes");

endmodule

bind request_block_splitter rbs_checker u_rbs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_byte_length  (req_byte_length),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_block_number (rsp_block_number),
   .rsp_piece_bytes  (rsp_piece_bytes),
   .rsp_last_piece   (rsp_last_piece)
);

// File: sim/tb_request_block_splitter.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_request_block_splitter
// Self-checking bench for the request block splitter. Request beats are
// offered with random gaps. Every accepted request is split here into the
// pieces the block should emit, and each result beat is checked field by
// field against the oldest piece still owed. The block size is changed only
// while the block is idle, across a range of legal and out-of-range values.
// ---------------------------------------------------------------------------
module tb_request_block_splitter;
   import rbs_pkg::*;

   // most pieces a single request can produce (4096 bytes over 128-byte blocks)
   localparam int MAX_PIECES  = (int'(MAX_REQUEST_BYTES) - 1) / int'(BLOCK_MIN) + 2;
   // divider latency plus margin, used after draining before touching the csr
   localparam int SETTLE      = 60;
   // length of the deliberate result-side hold-off
   localparam int LONG_HOLD   = 500;
   // cycles with no beat on any port before the run is declared hung
   localparam int STALL_LIMIT = 5000;
   localparam int NUM_PHASES  = 10;
   localparam int RAND_PER_PH = 11;

   typedef struct {
      logic [TAG_W-1:0]    tag;
      logic [BLKNUM_W-1:0] block;
      logic [BOFF_W-1:0]   boff;
      logic [ROFF_W-1:0]   roff;
      logic [LEN_W-1:0]    bytes;
      logic                last;
   } piece_type;

   // -----------------------------------------------------------------------
   // scoreboard: splits each accepted request, holds the pieces owed
   // -----------------------------------------------------------------------
   class piece_scoreboard;
      piece_type          owed_pieces[$];
      logic [BSIZE_W-1:0] block_size_reg;
      int                 errors;

      function new();
         block_size_reg = BLOCK_RESET;
         errors         = 0;
      endfunction

      function void set_block_size(logic [BSIZE_W-1:0] v);
         block_size_reg = v;
      endfunction

      // out-of-range sizes are clamped by the block
      function logic [BSIZE_W-1:0] effective_block();
         if (block_size_reg < BLOCK_MIN) return BLOCK_MIN;
         if (block_size_reg > BLOCK_MAX) return BLOCK_MAX;
         return block_size_reg;
      endfunction

      function int pending();
         return owed_pieces.size();
      endfunction

      function void note_request(logic [TAG_W-1:0] t, logic [ADDR_W-1:0] a,
                                 logic [LEN_W-1:0] l);
         logic [BSIZE_W-1:0] bs;
         logic [LEN_W-1:0]   eff_len;
         logic [LEN_W-1:0]   done;
         logic [ADDR_W:0]    last_byte;
         logic [ADDR_W:0]    first_blk;
         logic [ADDR_W:0]    end_blk;
         logic [ADDR_W:0]    cur;
         logic [ADDR_W:0]    boff_first;
         logic [BSIZE_W-1:0] size;
         piece_type          p;
         int                 n;
         if (l == '0) return;
         bs         = effective_block();
         eff_len    = (l > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : l;
         first_blk  = a / bs;
         // exact end block, may sit beyond the 41-bit output range
         last_byte  = {1'b0, a} + eff_len - 1;
         end_blk    = last_byte / bs;
         boff_first = a - first_blk * bs;
         done       = '0;
         cur        = first_blk;
         n          = 0;
         while (n < MAX_PIECES) begin
            p.tag   = t;
            p.block = cur[BLKNUM_W-1:0];
            p.boff  = (cur == first_blk) ? boff_first[BOFF_W-1:0] : '0;
            p.last  = (cur == end_blk);
            size    = p.last ? (eff_len - done) : (bs - p.boff);
            p.roff  = done[ROFF_W-1:0];
            p.bytes = size[LEN_W-1:0];
            owed_pieces.push_back(p);
            done = done + size[LEN_W-1:0];
            n++;
            if (p.last) break;
            cur++;
         end
      endfunction

      function void check_piece(piece_type got);
         piece_type want;
         if (owed_pieces.size() == 0) begin
            $error("piece beat with none owed: tag %h block %h", got.tag, got.block);
            errors++;
            return;
         end
         want = owed_pieces.pop_front();
         if (got.tag !== want.tag) begin
            $error("piece_tag: expected %h, got %h", want.tag, got.tag);
            errors++;
         end
         if (got.block !== want.block) begin
            $error("block_number: expected %h, got %h", want.block, got.block);
            errors++;
         end
         if (got.boff !== want.boff) begin
            $error("offset_in_block: expected %0d, got %0d", want.boff, got.boff);
            errors++;
         end
         if (got.roff !== want.roff) begin
            $error("offset_in_request: expected %0d, got %0d", want.roff, got.roff);
            errors++;
         end
         if (got.bytes !== want.bytes) begin
            $error("piece_bytes: expected %0d, got %0d", want.bytes, got.bytes);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last_piece: expected %b, got %b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // DUT signals; the inputs are driven to known values from time zero
   // -----------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [BSIZE_W-1:0]  csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [TAG_W-1:0]    req_tag = '0;
   logic [ADDR_W-1:0]   req_byte_address = '0;
   logic [LEN_W-1:0]    req_byte_length = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TAG_W-1:0]    rsp_piece_tag;
   logic [BLKNUM_W-1:0] rsp_block_number;
   logic [BOFF_W-1:0]   rsp_offset_in_block;
   logic [ROFF_W-1:0]   rsp_offset_in_request;
   logic [LEN_W-1:0]    rsp_piece_bytes;
   logic                rsp_last_piece;

   piece_scoreboard sb = new();

   // no_idle: both sides run flat out for a whole phase
   bit no_idle       = 1'b0;
   // long_hold_req: main asks the result side for one long hold-off
   bit long_hold_req = 1'b0;
   int idle_cycles   = 0;

   request_block_splitter uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_tag               (req_tag),
      .req_byte_address      (req_byte_address),
      .req_byte_length       (req_byte_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_piece_tag         (rsp_piece_tag),
      .rsp_block_number      (rsp_block_number),
      .rsp_offset_in_block   (rsp_offset_in_block),
      .rsp_offset_in_request (rsp_offset_in_request),
      .rsp_piece_bytes       (rsp_piece_bytes),
      .rsp_last_piece        (rsp_last_piece)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // per-beat random wait, zero when the phase runs without gaps
   function automatic int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 14);
   endfunction

   // -----------------------------------------------------------------------
   // request side: offer one beat after a random gap, hold it until taken.
   // Driven at the falling edge; the stall is looked at on the rising edge,
   // before the block's own updates land.
   // -----------------------------------------------------------------------
   task automatic send_request(input logic [TAG_W-1:0] t, input logic [ADDR_W-1:0] a,
                               input logic [LEN_W-1:0] l);
      int w;
      w = draw_wait();
      repeat (w) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_tag          <= t;
      req_byte_address <= a;
      req_byte_length  <= l;
      do @(posedge clock); while (req_stall);
      sb.note_request(t, a, l);
   endtask

   // stop offering, let every owed piece arrive, then idle a while before
   // the csr is touched
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one csr write; only ever called with the block idle
   task automatic write_block_size(input logic [BSIZE_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_block_size(v);
   endtask

   // -----------------------------------------------------------------------
   // result side: random stall per beat, plus one long hold-off on request
   // -----------------------------------------------------------------------
   initial begin : rsp_side
      int w;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            // block fills up and must stall the request side meanwhile
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
         end
         w = draw_wait();
         repeat (w) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // result monitor: a beat moves when valid is high and stall is low
   always @(posedge clock) begin : piece_monitor
      piece_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.tag   = rsp_piece_tag;
         seen.block = rsp_block_number;
         seen.boff  = rsp_offset_in_block;
         seen.roff  = rsp_offset_in_request;
         seen.bytes = rsp_piece_bytes;
         seen.last  = rsp_last_piece;
         sb.check_piece(seen);
      end
   end

   // watchdog: any beat or csr write restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $error("no beat for %0d cycles, %0d pieces still owed", STALL_LIMIT, sb.pending());
         $display("request_block_splitter test failed");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // main sequence
   // -----------------------------------------------------------------------
   initial begin : stimulus
      logic [BSIZE_W-1:0] sizes [NUM_PHASES];
      logic [BSIZE_W-1:0] bs;
      logic [ADDR_W-1:0]  addr;
      logic [LEN_W-1:0]   len;
      int                 sel;
      // phase 0 runs on the reset size; the rest include both clamp sides
      sizes = '{17'd4096, 17'd128, 17'd65536, 17'd0, 17'h1FFFF,
                17'd1000, 17'd127, 17'd65537, 17'd3000, 17'd129};

      // synchronous reset held high from time zero, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            write_block_size(sizes[ph]);
         end
         no_idle = (ph % 4 == 3);

         if (ph == 0) begin
            // directed: field extremes, zero length, overlong, boundary cases
            send_request('0, '0, 13'd1);
            send_request('1, '1, 13'd1);
            send_request(32'h1234_5678, 48'h0000_0000_1000, 13'd0);
            send_request(32'hA5A5_A5A5, '0, MAX_REQUEST_BYTES);
            send_request(32'h5A5A_5A5A, 48'd1, MAX_REQUEST_BYTES);
            send_request(32'h0000_FFFF, 48'd100, 13'h1FFF);
            send_request(32'hFFFF_0000, 48'd4095, 13'd2);
            send_request(32'h0F0F_0F0F, 48'd4095, 13'd4097);
            send_request(32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 13'h1555);
            send_request(32'h5555_5555, 48'h5555_5555_5555, 13'h0AAA);
            send_request(32'h8000_0001, 48'h8000_0000_0000, MAX_REQUEST_BYTES);
            send_request(32'hDEAD_0001, 48'hFFFF_FFFF_FFF5, MAX_REQUEST_BYTES);
            send_request(32'hDEAD_0002, 48'hFFFF_FFFF_F000, MAX_REQUEST_BYTES);
            // zero-length beats back to back, then a normal one straight after
            send_request(32'h0000_0001, 48'h0000_0000_0FFF, 13'd0);
            send_request(32'hFFFF_FFFE, 48'h7FFF_FFFF_FFFF, 13'd0);
            send_request(32'h0000_0002, 48'h0000_0000_0FFF, 13'd1);
         end

         // every phase: a request crossing the top of the address space
         // (block numbers wrap at the smallest size) and an overlong one
         send_request($urandom,
                      48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 2000)),
                      MAX_REQUEST_BYTES);
         send_request($urandom, '0, 13'h1FFF);

         bs = sb.effective_block();
         for (int i = 0; i < RAND_PER_PH; i++) begin
            if (ph == 1 && i == 4) long_hold_req = 1'b1;
            // sender pause: wait for every owed piece mid-phase
            if (ph == 2 && i == 8) drain();

            sel = $urandom_range(0, 19);
            if (sel == 0)       len = '0;
            else if (sel <= 2)  len = LEN_W'($urandom_range(4097, 8191));
            else if (sel <= 5)  len = MAX_REQUEST_BYTES;
            else if (sel <= 12) len = LEN_W'($urandom_range(1, 300));
            else                len = LEN_W'($urandom_range(1, 4096));

            addr = ADDR_W'({$urandom, $urandom});
            sel  = $urandom_range(0, 9);
            if (sel < 3)
               // start just short of a block boundary
               addr = addr - (addr % bs) + bs - ADDR_W'($urandom_range(1, 16));
            else if (sel == 3)
               addr = 48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 8191));
            else if (sel == 4)
               addr = ADDR_W'($urandom_range(0, 8191));

            send_request($urandom, addr, len);
         end
      end

      // put the reset size back and end on two more beats
      drain();
      write_block_size(BLOCK_RESET);
      send_request($urandom, ADDR_W'({$urandom, $urandom}),
                   LEN_W'($urandom_range(1, 4096)));
      send_request($urandom, ADDR_W'({$urandom, $urandom}),
                   LEN_W'($urandom_range(1, 4096)));
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("request_block_splitter test passed");
      end else begin
         $display("request_block_splitter test failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/rbs_pkg.sv
design/rbs_ctrl.sv
design/rbs_datapath.sv
design/request_block_splitter.sv
design/rbs_checker.sv
sim/tb_request_block_splitter.sv
